@@ hdl/ccfd_pkg.sv @@
package ccfd_pkg;

   localparam int DATA_BYTES    = 30;
   localparam int JOINT_COUNT   = 7;
   localparam int JOINT_FIELDS  = 7;

   localparam int FRAME_LEN     = DATA_BYTES + 9;
   localparam int POS_W         = $clog2(FRAME_LEN + 2);
   localparam int PAYLOAD_FIRST = 7;
   localparam int PAYLOAD_LEN   = 29;
   localparam int OFF_W         = $clog2(PAYLOAD_LEN);
   localparam int RAM_DEPTH     = (PAYLOAD_LEN + 3) / 4;
   localparam int RAM_AW        = $clog2(RAM_DEPTH);
   localparam int GRIP_WORD     = (PAYLOAD_LEN - 1) / 4;
   localparam int GRIP_LANE     = (PAYLOAD_LEN - 1) % 4;

   localparam logic [7:0]  START_RESET   = 8'hA5;
   localparam logic [15:0] COMMAND_RESET = 16'h0302;
   localparam logic [7:0]  HCRC_INIT     = 8'hFF;
   localparam logic [15:0] FCRC_INIT     = 16'hFFFF;

   localparam logic CSR_START   = 1'b0;
   localparam logic CSR_COMMAND = 1'b1;

   typedef logic [2:0] status_type;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_WRONG_LEN = 3'd1;
   localparam status_type ST_BAD_START = 3'd2;
   localparam status_type ST_HEADER   = 3'd3;
   localparam status_type ST_DATA_LEN  = 3'd4;
   localparam status_type ST_COMMAND   = 3'd5;
   localparam status_type ST_FRAME_CRC = 3'd6;

   typedef struct packed {
      logic       valid;
      status_type status;
   } res_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ hdl/ccfd_ram.sv @@
module ccfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ccfd_check.sv @@
module ccfd_check import ccfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   input  logic              burst_end,
   input  logic [7:0]        start_byte,
   input  logic [15:0]       command_code,
   output res_type           res,
   output logic              wr_en,
   output logic [RAM_AW-1:0] wr_addr,
   output logic [31:0]       wr_data
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       hcrc_ff, hcrc_in;
   logic [15:0]      fcrc_ff, fcrc_in;
   status_type       fault_ff, fault_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [7:0]       cmd_lo_ff, cmd_lo_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [23:0]      acc_ff, acc_in;

   status_type       code;
   logic [POS_W-1:0] off_full;
   logic [OFF_W-1:0] off;
   logic             in_payload;

   assign off_full   = pos_ff - POS_W'(PAYLOAD_FIRST);
   assign off        = off_full[OFF_W-1:0];
   assign in_payload = (pos_ff >= POS_W'(PAYLOAD_FIRST))
                    && (pos_ff < POS_W'(PAYLOAD_FIRST + PAYLOAD_LEN));

   always_comb begin
      pos_in    = pos_ff;
      hcrc_in   = hcrc_ff;
      fcrc_in   = fcrc_ff;
      fault_in  = fault_ff;
      len_lo_in = len_lo_ff;
      cmd_lo_in = cmd_lo_ff;
      crc_lo_in = crc_lo_ff;
      acc_in    = acc_ff;
      code      = ST_OK;
      wr_en     = 1'b0;
      wr_addr   = off[RAM_AW+1:2];
      wr_data   = (off[1:0] == 2'd3) ? {rx_byte, acc_ff} : {24'h000000, rx_byte};
      res.valid  = 1'b0;
      res.status = ST_OK;
      if (accept) begin
         if (pos_ff < POS_W'(FRAME_LEN)) begin
            if (pos_ff <= POS_W'(3)) begin
               hcrc_in = crc8_step(hcrc_ff, rx_byte);
            end
            if (pos_ff <= POS_W'(FRAME_LEN - 3)) begin
               fcrc_in = crc16_step(fcrc_ff, rx_byte);
            end
            if (pos_ff == POS_W'(0)) begin
               if (rx_byte != start_byte) begin
                  code = ST_BAD_START;
               end
            end else if (pos_ff == POS_W'(1)) begin
               len_lo_in = rx_byte;
            end else if (pos_ff == POS_W'(2)) begin
               if ({rx_byte, len_lo_ff} != 16'(DATA_BYTES)) begin
                  code = ST_DATA_LEN;
               end
            end else if (pos_ff == POS_W'(4)) begin
               if (rx_byte != hcrc_ff) begin
                  code = ST_HEADER;
               end
            end else if (pos_ff == POS_W'(5)) begin
               cmd_lo_in = rx_byte;
            end else if (pos_ff == POS_W'(6)) begin
               if ({rx_byte, cmd_lo_ff} != command_code) begin
                  code = ST_COMMAND;
               end
            end else if (pos_ff == POS_W'(FRAME_LEN - 2)) begin
               crc_lo_in = rx_byte;
            end else if (pos_ff == POS_W'(FRAME_LEN - 1)) begin
               if ({rx_byte, crc_lo_ff} != fcrc_ff) begin
                  code = ST_FRAME_CRC;
               end
            end
            if (in_payload) begin
               acc_in = {rx_byte, acc_ff[23:8]};
               wr_en  = (off[1:0] == 2'd3) || (off == OFF_W'(PAYLOAD_LEN - 1));
            end
         end
         if (code != ST_OK && (fault_ff == ST_OK || code < fault_ff)) begin
            fault_in = code;
         end
         if (pos_ff <= POS_W'(FRAME_LEN)) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (burst_end) begin
            res.valid  = 1'b1;
            res.status = (pos_in != POS_W'(FRAME_LEN)) ? ST_WRONG_LEN : fault_in;
            pos_in    = '0;
            hcrc_in   = HCRC_INIT;
            fcrc_in   = FCRC_INIT;
            fault_in  = ST_OK;
            len_lo_in = 8'h00;
            cmd_lo_in = 8'h00;
            crc_lo_in = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hcrc_ff   <= HCRC_INIT;
         fcrc_ff   <= FCRC_INIT;
         fault_ff  <= ST_OK;
         len_lo_ff <= 8'h00;
         cmd_lo_ff <= 8'h00;
         crc_lo_ff <= 8'h00;
      end else begin
         pos_ff    <= pos_in;
         hcrc_ff   <= hcrc_in;
         fcrc_ff   <= fcrc_in;
         fault_ff  <= fault_in;
         len_lo_ff <= len_lo_in;
         cmd_lo_ff <= cmd_lo_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

@@ hdl/ccfd_slot.sv @@
module ccfd_slot import ccfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  res_type           res,
   output logic              rd_en,
   output logic [RAM_AW-1:0] rd_addr,
   input  logic [31:0]       rd_data,
   output logic              free,
   output logic              out_valid,
   input  logic              out_ready,
   output status_type        out_status,
   output logic [31:0]       out_joint [JOINT_FIELDS],
   output logic [7:0]        out_gripper
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FILL = 2'd1;
   localparam logic [1:0] S_FULL = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [RAM_AW:0]   cnt_ff, cnt_in;
   status_type        status_ff, status_in;
   logic [31:0]       joint_ff [JOINT_FIELDS];
   logic [7:0]        grip_ff;
   logic [RAM_AW-1:0] cap_idx;
   logic [RAM_AW:0]   cnt_dec;
   logic              capture;

   assign cnt_dec = cnt_ff - (RAM_AW + 1)'(1);
   assign cap_idx = cnt_dec[RAM_AW-1:0];
   assign capture = (state_ff == S_FILL) && (cnt_ff != '0);
   assign rd_en   = (state_ff == S_FILL) && (cnt_ff < (RAM_AW + 1)'(RAM_DEPTH));
   assign rd_addr = cnt_ff[RAM_AW-1:0];
   assign free    = (state_ff == S_IDLE) || ((state_ff == S_FULL) && out_ready);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      unique case (state_ff) inside
         S_IDLE, S_FULL: begin
            if (state_ff == S_FULL && out_ready) begin
               state_in = S_IDLE;
            end
            if (free && res.valid) begin
               status_in = res.status;
               cnt_in    = '0;
               state_in  = (res.status == ST_OK) ? S_FILL : S_FULL;
            end
         end
         S_FILL: begin
            cnt_in = cnt_ff + (RAM_AW + 1)'(1);
            if (cnt_ff == (RAM_AW + 1)'(RAM_DEPTH)) begin
               state_in = S_FULL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && res.valid && res.status != ST_OK) begin
         for (int j = 0; j < JOINT_FIELDS; j++) begin
            joint_ff[j] <= 32'h0;
         end
         grip_ff <= 8'h00;
      end else if (capture) begin
         for (int j = 0; j < JOINT_FIELDS; j++) begin
            if (cap_idx == RAM_AW'(j)) begin
               joint_ff[j] <= (j < JOINT_COUNT) ? rd_data : 32'h0;
            end
         end
         if (cap_idx == RAM_AW'(GRIP_WORD)) begin
            grip_ff <= rd_data[8*GRIP_LANE +: 8];
         end
      end
   end

   assign out_valid   = (state_ff == S_FULL);
   assign out_status  = status_ff;
   assign out_joint   = joint_ff;
   assign out_gripper = grip_ff;

endmodule

@@ hdl/crc_checked_control_frame_deframer.sv @@
// Control-frame deframer for a serial receive path.
// req channel: one received byte per word in req_tdata, req_tlast marks the
// last byte before an idle line. Each tlast word closes a burst and yields
// one rsp word: status in rsp_tuser, seven joint words and the gripper byte
// in rsp_tdata (all zero unless status is ok).
// Bytes are taken one per cycle except a stalled tlast word; CRC8 header
// and CRC16 frame checks run on the fly, payload bytes are packed into
// 32-bit words of an 8-entry RAM. A result with ok status reaches
// rsp_tvalid once the slot has read every RAM word back through the
// registered read port; a failed frame shows rsp_tvalid on the next cycle.
// The result sits in an output slot while the next burst keeps streaming;
// only a tlast word waits (req_tready low) while the slot is still filling
// or holds a result the receiver has not taken.
// Reset clears the framing state and the slot, and loads start byte 0xA5
// and command 0x0302. csr registers: start_byte at 0x0, command_code at 0x4;
// write them only while no burst is in flight.
module crc_checked_control_frame_deframer import ccfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [231:0] rsp_tdata,   // joint_0..joint_6 (32 each), gripper
   output logic [2:0]   rsp_tuser,   // status
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [7:0]        start_byte_ff;
   logic [15:0]       command_code_ff;
   logic              csr_wr;
   logic              accept;
   res_type           res;
   logic              wr_en;
   logic [RAM_AW-1:0] wr_addr;
   logic [31:0]       wr_data;
   logic              rd_en;
   logic [RAM_AW-1:0] rd_addr;
   logic [31:0]       rd_data;
   logic              slot_free;
   logic [31:0]       joint [JOINT_FIELDS];
   logic [7:0]        gripper;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_COMMAND) ? {16'h0000, command_code_ff}
                                                     : {24'h000000, start_byte_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= START_RESET;
         command_code_ff <= COMMAND_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_START) begin
            start_byte_ff <= csr_pwdata[7:0];
         end else begin
            command_code_ff <= csr_pwdata[15:0];
         end
      end
   end

   assign req_tready = !req_tlast || slot_free;
   assign accept     = req_tvalid && req_tready;

   ccfd_check u_check (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_tdata),
      .burst_end    (req_tlast),
      .start_byte   (start_byte_ff),
      .command_code (command_code_ff),
      .res          (res),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   ccfd_ram #(
      .WIDTH (32),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ccfd_slot u_slot (
      .clock       (clock),
      .reset       (reset),
      .res         (res),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .free        (slot_free),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_status  (rsp_tuser),
      .out_joint   (joint),
      .out_gripper (gripper)
   );

   assign rsp_tdata = {gripper, joint[6], joint[5], joint[4], joint[3],
                       joint[2], joint[1], joint[0]};

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("failed frame carries payload");

   a_stall_last: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> req_tlast)
      else $error("non-final byte stalled");

   a_no_collide: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("payload write hits word under readout");

   a_result_taken: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast && res.status != ST_OK) |=> rsp_tvalid)
      else $error("failed frame result not presented");

endmodule

@@ tb/crc_checked_control_frame_deframer_tb.sv @@
module crc_checked_control_frame_deframer_tb import ccfd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_PAD   = 16;
   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASES      = 3;
   localparam int PHASE_WORDS = 100;

   localparam logic [7:0]  HCRC_POLY = 8'h8C;
   localparam logic [15:0] FCRC_POLY = 16'h8408;

   localparam logic [2:0] START_ADDR   = {CSR_START, 2'b00};
   localparam logic [2:0] COMMAND_ADDR = {CSR_COMMAND, 2'b00};

   localparam logic [4:0] F_NONE  = 5'd0;
   localparam logic [4:0] F_START = 5'd1;
   localparam logic [4:0] F_HCRC  = 5'd2;
   localparam logic [4:0] F_LEN   = 5'd4;
   localparam logic [4:0] F_CMD   = 5'd8;
   localparam logic [4:0] F_FCRC  = 5'd16;

   localparam logic [1:0] FILL_RANDOM = 2'd0;
   localparam logic [1:0] FILL_ZERO   = 2'd1;
   localparam logic [1:0] FILL_ONES   = 2'd2;

   localparam logic [5:0] FULL = 6'(FRAME_LEN);

   typedef struct packed {
      status_type       status;
      logic [6:0][31:0] joints;
      logic [7:0]       gripper;
   } decoded_type;

   typedef struct packed {
      logic [4:0] faults;
      logic [5:0] total;
      logic [1:0] fill;
      logic       pinned;
      status_type status;
   } burst_case_type;

   logic         clock;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata   = 8'h00;   // [7:0] rx_byte
   logic         req_tlast   = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [231:0] rsp_tdata;             // joint_0..joint_6 (32 each), gripper
   logic [2:0]   rsp_tuser;             // status
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [2:0]   csr_paddr   = 3'd0;
   logic [31:0]  csr_pwdata  = 32'd0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   logic [7:0]  start_val = START_RESET;
   logic [15:0] cmd_val   = COMMAND_RESET;

   int          rx_count  = 0;
   logic [7:0]  hdr_crc   = HCRC_INIT;
   logic [15:0] frm_crc   = FCRC_INIT;
   status_type  fault_code = ST_OK;
   logic [7:0]  len_lo    = 8'h00;
   logic [7:0]  cmd_lo    = 8'h00;
   logic [7:0]  crc_lo    = 8'h00;
   logic [7:0]  payload_bytes [PAYLOAD_LEN];

   decoded_type expected_frames [$];
   logic [7:0]  burst_bytes [$];

   int mismatches   = 0;
   int items_sent   = 0;
   int bursts_sent  = 0;
   int results_seen = 0;
   int settings_run = 0;
   int status_hits [8];
   int idle_cycles  = 0;
   bit hold_request = 1'b0;

   burst_case_type directed_cases [16] = '{
      '{F_NONE,                 6'd1,         FILL_RANDOM, 1'b1, ST_WRONG_LEN},
      '{F_NONE,                 FULL,         FILL_ZERO,   1'b0, ST_OK},
      '{F_NONE,                 FULL,         FILL_ONES,   1'b0, ST_OK},
      '{F_NONE,                 FULL,         FILL_RANDOM, 1'b0, ST_OK},
      '{F_START,                FULL,         FILL_RANDOM, 1'b1, ST_BAD_START},
      '{F_HCRC,                 FULL,         FILL_RANDOM, 1'b1, ST_HEADER},
      '{F_LEN,                  FULL,         FILL_RANDOM, 1'b1, ST_DATA_LEN},
      '{F_CMD,                  FULL,         FILL_RANDOM, 1'b1, ST_COMMAND},
      '{F_FCRC,                 FULL,         FILL_ONES,   1'b1, ST_FRAME_CRC},
      '{F_START | F_CMD | F_FCRC, FULL,       FILL_RANDOM, 1'b1, ST_BAD_START},
      '{F_HCRC | F_LEN,         FULL,         FILL_RANDOM, 1'b1, ST_HEADER},
      '{F_CMD | F_FCRC,         FULL,         FILL_ZERO,   1'b1, ST_COMMAND},
      '{F_NONE,                 FULL - 6'd1,  FILL_RANDOM, 1'b1, ST_WRONG_LEN},
      '{F_NONE,                 FULL + 6'd1,  FILL_RANDOM, 1'b1, ST_WRONG_LEN},
      '{F_START,                FULL + 6'd8,  FILL_ONES,   1'b1, ST_WRONG_LEN},
      '{F_NONE,                 6'd2,         FILL_ONES,   1'b1, ST_WRONG_LEN}
   };

   crc_checked_control_frame_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      repeat (8) c = {1'b0, c[7:1]} ^ (c[0] ? HCRC_POLY : 8'h00);
      return c;
   endfunction

   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = {1'b0, c[15:1]} ^ (c[0] ? FCRC_POLY : 16'h0000);
      return c;
   endfunction

   function automatic void note_fault(input status_type code);
      if (fault_code == ST_OK || code < fault_code)
         fault_code = code;
   endfunction

   // track one byte through the framer; returns 1 when the byte closes a burst
   function automatic bit advance_frame(input logic [7:0] b, input logic last,
                                        output decoded_type res);
      int pos;
      status_type st;
      pos = rx_count;
      res = '0;
      if (pos < FRAME_LEN) begin
         if (pos <= 3)
            hdr_crc = crc8_next(hdr_crc, b);
         if (pos <= FRAME_LEN - 3)
            frm_crc = crc16_next(frm_crc, b);
         case (pos)
            0: if (b != start_val) note_fault(ST_BAD_START);
            1: len_lo = b;
            2: if ({b, len_lo} != 16'(DATA_BYTES)) note_fault(ST_DATA_LEN);
            4: if (b != hdr_crc) note_fault(ST_HEADER);
            5: cmd_lo = b;
            6: if ({b, cmd_lo} != cmd_val) note_fault(ST_COMMAND);
            FRAME_LEN - 2: crc_lo = b;
            FRAME_LEN - 1: if ({b, crc_lo} != frm_crc) note_fault(ST_FRAME_CRC);
            default: ;
         endcase
         if (pos >= PAYLOAD_FIRST && pos < PAYLOAD_FIRST + PAYLOAD_LEN)
            payload_bytes[pos - PAYLOAD_FIRST] = b;
      end
      if (pos <= FRAME_LEN)
         rx_count = pos + 1;
      if (!last)
         return 1'b0;
      st = (rx_count != FRAME_LEN) ? ST_WRONG_LEN : fault_code;
      res.status = st;
      if (st == ST_OK) begin
         for (int j = 0; j < JOINT_COUNT; j++)
            res.joints[j] = {payload_bytes[4*j+3], payload_bytes[4*j+2],
                             payload_bytes[4*j+1], payload_bytes[4*j]};
         res.gripper = payload_bytes[PAYLOAD_LEN - 1];
      end
      rx_count   = 0;
      hdr_crc    = HCRC_INIT;
      frm_crc    = FCRC_INIT;
      fault_code = ST_OK;
      len_lo     = 8'h00;
      cmd_lo     = 8'h00;
      crc_lo     = 8'h00;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_byte(input logic [1:0] fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] nonzero_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   // build a frame for the current settings, corrupt the flagged fields, then cut or pad
   function automatic void make_frame(input logic [4:0] faults, input int total,
                                      input logic [1:0] fill);
      logic [7:0]  f [FRAME_LEN];
      logic [7:0]  hc;
      logic [15:0] fc;
      f[0] = start_val ^ ((faults & F_START) != 0 ? nonzero_byte() : 8'h00);
      {f[2], f[1]} = 16'(DATA_BYTES) ^
                     ((faults & F_LEN) != 0 ? 16'($urandom_range(1, 65535)) : 16'h0000);
      f[3] = pick_byte(fill);
      hc = HCRC_INIT;
      for (int i = 0; i < 4; i++)
         hc = crc8_next(hc, f[i]);
      f[4] = hc ^ ((faults & F_HCRC) != 0 ? nonzero_byte() : 8'h00);
      {f[6], f[5]} = cmd_val ^
                     ((faults & F_CMD) != 0 ? 16'($urandom_range(1, 65535)) : 16'h0000);
      for (int i = PAYLOAD_FIRST; i < FRAME_LEN - 2; i++)
         f[i] = pick_byte(fill);
      fc = FCRC_INIT;
      for (int i = 0; i < FRAME_LEN - 2; i++)
         fc = crc16_next(fc, f[i]);
      {f[FRAME_LEN-1], f[FRAME_LEN-2]} =
         fc ^ ((faults & F_FCRC) != 0 ? 16'($urandom_range(1, 65535)) : 16'h0000);
      burst_bytes.delete();
      for (int i = 0; i < total; i++)
         burst_bytes.push_back(i < FRAME_LEN ? f[i] : pick_byte(fill));
   endfunction

   task automatic flag_error(input string what, input logic [31:0] got,
                             input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // call right after a rising edge
   task automatic send_burst(input bit pinned, input status_type pin_status);
      decoded_type res;
      decoded_type pin_res;
      bit gappy;
      bit last;
      int gap;
      gappy = ($urandom_range(0, 3) != 0);
      foreach (burst_bytes[i]) begin
         gap = gappy ? $urandom_range(0, 6) : 0;
         last = (i == burst_bytes.size() - 1);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tdata  <= burst_bytes[i];
         req_tlast  <= last;
         req_tvalid <= 1'b1;
         do @(posedge clock); while (!req_tready);
         items_sent++;
         if (advance_frame(burst_bytes[i], last, res)) begin
            pin_res = '0;
            pin_res.status = pin_status;
            expected_frames.push_back(pinned ? pin_res : res);
         end
      end
      bursts_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [2:0] addr, output logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] sb, input logic [15:0] cc);
      logic [31:0] rd;
      csr_write(START_ADDR, {24'($urandom), sb});
      start_val = sb;
      csr_write(COMMAND_ADDR, {16'($urandom), cc});
      cmd_val = cc;
      csr_read(START_ADDR, rd);
      if (rd[7:0] !== start_val)
         flag_error("start_byte readback", {24'd0, rd[7:0]}, {24'd0, start_val});
      csr_read(COMMAND_ADDR, rd);
      if (rd[15:0] !== cmd_val)
         flag_error("command_code readback", {16'd0, rd[15:0]}, {16'd0, cmd_val});
      settings_run++;
   endtask

   task automatic random_burst();
      int pick;
      int n;
      logic [1:0] fill;
      pick = $urandom_range(0, 99);
      fill = ($urandom_range(0, 9) == 0) ?
             ($urandom_range(0, 1) ? FILL_ZERO : FILL_ONES) : FILL_RANDOM;
      if (pick < 55) begin
         make_frame(F_NONE, FRAME_LEN, fill);
      end else if (pick < 65) begin
         make_frame(5'(1 << $urandom_range(0, 4)), FRAME_LEN, fill);
      end else if (pick < 75) begin
         make_frame(5'($urandom_range(1, 31)), FRAME_LEN, fill);
      end else if (pick < 85) begin
         n = $urandom_range(0, 1) ? $urandom_range(FRAME_LEN - 5, FRAME_LEN - 1)
                                  : $urandom_range(FRAME_LEN + 1, FRAME_LEN + 7);
         make_frame(5'($urandom_range(0, 31)), n, fill);
      end else begin
         n = $urandom_range(1, 8);
         burst_bytes.delete();
         repeat (n) burst_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 1))
            burst_bytes[0] = start_val;
      end
      send_burst(1'b0, ST_OK);
   endtask

   always @(posedge clock) begin : check_result
      decoded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_frames.size() == 0) begin
            flag_error("result with nothing pending", {29'd0, rsp_tuser}, 32'd0);
         end else begin
            want = expected_frames.pop_front();
            status_hits[want.status]++;
            if (rsp_tuser !== want.status)
               flag_error("status", {29'd0, rsp_tuser}, {29'd0, want.status});
            for (int j = 0; j < 7; j++)
               if (rsp_tdata[32*j +: 32] !== want.joints[j])
                  flag_error($sformatf("joint_%0d", j), rsp_tdata[32*j +: 32],
                             want.joints[j]);
            if (rsp_tdata[231:224] !== want.gripper)
               flag_error("gripper", {24'd0, rsp_tdata[231:224]}, {24'd0, want.gripper});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results pending",
                  IDLE_LIMIT, expected_frames.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin : receiver
      int n;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            n = ((taken % 32) < 8) ? 0 : $urandom_range(0, 6);
            if (n != 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin : stimulus
      int phase_start;
      int phase_bursts;
      logic [7:0]  sb;
      logic [15:0] cc;
      foreach (payload_bytes[i]) payload_bytes[i] = 8'h00;
      foreach (status_hits[i]) status_hits[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_cases[i]) begin
         make_frame(directed_cases[i].faults, int'(directed_cases[i].total),
                    directed_cases[i].fill);
         send_burst(directed_cases[i].pinned, directed_cases[i].status);
      end
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin sb = 8'h00; cc = 16'h0000; end
            1: begin sb = 8'hFF; cc = 16'hFFFF; end
            default: begin sb = 8'($urandom); cc = 16'($urandom); end
         endcase
         apply_settings(sb, cc);
         if (phase == 1)
            hold_request = 1'b1;
         phase_start = items_sent;
         phase_bursts = 0;
         while (items_sent - phase_start < PHASE_WORDS || phase_bursts < 4) begin
            random_burst();
            phase_bursts++;
            // hold the sender until all pending results are back
            if (phase_bursts == 6)
               wait_drained();
         end
         wait_drained();
      end

      $display("sent %0d bytes in %0d bursts under %0d register settings, %0d results checked",
               items_sent, bursts_sent, settings_run + 1, results_seen);
      $display("results by status ok/len/start/hcrc/dlen/cmd/fcrc: %0d %0d %0d %0d %0d %0d %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4], status_hits[5], status_hits[6]);
      if (mismatches == 0 && expected_frames.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/ccfd_pkg.sv
hdl/ccfd_ram.sv
hdl/ccfd_check.sv
hdl/ccfd_slot.sv
hdl/crc_checked_control_frame_deframer.sv
tb/crc_checked_control_frame_deframer_tb.sv
